/* hw/rtl/thb_pkg.sv */
// Shared types and constants for the IPv4/TCP header builder.
// No dependencies; imported by every module of the block.
package thb_pkg;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [16:0] LEN_LIMIT = 17'd65495;
  localparam logic [15:0] IP_HLEN   = 16'd40;
  localparam logic [15:0] TCP_HLEN  = 16'd20;
  localparam logic [7:0]  VER_IHL   = 8'h45;
  localparam logic [7:0]  PROTO_TCP = 8'h06;
  localparam logic [7:0]  DATA_OFF  = 8'h50;
  localparam logic [15:0] WINDOW    = 16'hFFFF;

  localparam logic [2:0] WORD_IP0  = 3'd0;
  localparam logic [2:0] WORD_IP1  = 3'd1;
  localparam logic [2:0] WORD_ADDR = 3'd2;
  localparam logic [2:0] WORD_SEQ  = 3'd3;
  localparam logic [2:0] WORD_TCP  = 3'd4;

  // One header request: header fields plus the closing payload sum and count
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  flag_bits;
    logic [7:0]  ttl;
    logic [15:0] ident;
    logic [31:0] seq_num;
    logic [16:0] count;
    logic [31:0] sum;
  } thb_req_t;

  // Partial checksum sums after the first back-end stage
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  flag_bits;
    logic [7:0]  ttl;
    logic [15:0] ident;
    logic [31:0] seq_num;
    logic [15:0] tot_len;
    logic        err;
    logic [18:0] ip_part;
    logic [17:0] addr_part;
    logic [18:0] tcp_a;
    logic [17:0] tcp_b;
  } thb_s1_t;

  // Finished header held while its five words drain
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  flag_bits;
    logic [7:0]  ttl;
    logic [15:0] ident;
    logic [31:0] seq_num;
    logic [15:0] tot_len;
    logic        err;
    logic [15:0] ip_ck;
    logic [15:0] tcp_ck;
  } thb_hdr_t;

  // Ones'-complement fold of a sum of at most 21 bits; two folds suffice
  function automatic logic [15:0] fold16(input logic [20:0] s);
    logic [16:0] t1;
    logic [16:0] t2;
    t1 = {1'b0, s[15:0]} + {12'd0, s[20:16]};
    t2 = {1'b0, t1[15:0]} + {16'd0, t1[16]};
    return t2[15:0];
  endfunction

endpackage

/* hw/rtl/thb_queue.sv */
// Short request queue between the front and back parts of the header builder.
// Depends on thb_pkg for the request type.
module thb_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  thb_pkg::thb_req_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output thb_pkg::thb_req_t pop_data
);
  import thb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  thb_req_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/thb_front.sv */
// Front part: takes payload bytes, keeps the running ones'-complement sum
// and byte count, and queues a header request on the last item. Uses thb_pkg.
module thb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [31:0]       in_src_addr,
  input  logic [31:0]       in_dst_addr,
  input  logic [15:0]       in_sport,
  input  logic [15:0]       in_dport,
  input  logic [7:0]        in_flag_bits,
  input  logic [7:0]        in_ttl,
  input  logic [15:0]       in_ident,
  input  logic [31:0]       in_seq_num,
  input  logic [7:0]        in_payload_byte,
  input  logic              in_byte_valid,
  input  logic              in_last,
  output logic              req_push,
  output thb_pkg::thb_req_t req_data,
  input  logic              req_full
);
  import thb_pkg::*;

  logic [31:0] sum_r, sum_nxt;
  logic [16:0] count_r, count_nxt;
  logic [31:0] sum_upd;
  logic [16:0] count_upd;
  logic [31:0] addend;
  logic [32:0] raw;
  logic        accept, take;

  assign in_full = req_full;
  assign accept  = in_push && !req_full;
  assign take    = in_byte_valid && (count_r != COUNT_MAX);

  // Even byte positions are the high half of a 16-bit pair
  assign addend = count_r[0] ? {24'd0, in_payload_byte} : {16'd0, in_payload_byte, 8'd0};
  assign raw    = {1'b0, sum_r} + {1'b0, addend};

  always_comb begin
    sum_upd   = sum_r;
    count_upd = count_r;
    if (take) begin
      // end-around carry
      sum_upd   = raw[31:0] + {31'd0, raw[32]};
      count_upd = count_r + 1'b1;
    end
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (accept) begin
      sum_nxt   = in_last ? '0 : sum_upd;
      count_nxt = in_last ? '0 : count_upd;
    end
  end

  assign req_push = accept && in_last;

  always_comb begin
    req_data.src_addr  = in_src_addr;
    req_data.dst_addr  = in_dst_addr;
    req_data.sport     = in_sport;
    req_data.dport     = in_dport;
    req_data.flag_bits = in_flag_bits;
    req_data.ttl       = in_ttl;
    req_data.ident     = in_ident;
    req_data.seq_num   = in_seq_num;
    req_data.count     = count_upd;
    req_data.sum       = sum_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/thb_back.sv */
// Back part: two checksum stages and a header slot that drains as five
// 64-bit words in wire order. Uses thb_pkg.
module thb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  thb_pkg::thb_req_t req_data,
  output logic              req_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [63:0]       out_header_word,
  output logic [2:0]        out_word_index,
  output logic              out_length_error,
  output logic              out_last_word
);
  import thb_pkg::*;

  thb_s1_t     s1_r, s1_nxt;
  logic        s1_v_r, s1_v_nxt;
  thb_hdr_t    hdr_r, hdr_nxt;
  logic        hdr_v_r, hdr_v_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        hdr_done, hdr_free, s1_adv, s1_ready;
  logic [15:0] tcp_len;
  logic [18:0] ip_pre;
  logic [20:0] tcp_total;

  assign hdr_done = hdr_v_r && out_pop && (idx_r == WORD_TCP);
  assign hdr_free = !hdr_v_r || hdr_done;
  assign s1_adv   = s1_v_r && hdr_free;
  assign s1_ready = !s1_v_r || hdr_free;
  assign req_pop  = req_valid && s1_ready;

  // Stage one: lengths and partial sums
  assign tcp_len = req_data.count[15:0] + TCP_HLEN;
  always_comb begin
    s1_nxt.src_addr  = req_data.src_addr;
    s1_nxt.dst_addr  = req_data.dst_addr;
    s1_nxt.sport     = req_data.sport;
    s1_nxt.dport     = req_data.dport;
    s1_nxt.flag_bits = req_data.flag_bits;
    s1_nxt.ttl       = req_data.ttl;
    s1_nxt.ident     = req_data.ident;
    s1_nxt.seq_num   = req_data.seq_num;
    s1_nxt.tot_len   = req_data.count[15:0] + IP_HLEN;
    s1_nxt.err       = (req_data.count > LEN_LIMIT);
    s1_nxt.addr_part = {2'd0, req_data.src_addr[31:16]} + {2'd0, req_data.src_addr[15:0]}
                     + {2'd0, req_data.dst_addr[31:16]} + {2'd0, req_data.dst_addr[15:0]};
    ip_pre           = {3'd0, VER_IHL, 8'd0} + {3'd0, s1_nxt.tot_len}
                     + {3'd0, req_data.ident} + {3'd0, req_data.ttl, PROTO_TCP};
    s1_nxt.ip_part   = ip_pre + {1'b0, s1_nxt.addr_part};
    s1_nxt.tcp_a     = {11'd0, PROTO_TCP} + {3'd0, tcp_len}
                     + {3'd0, req_data.sport} + {3'd0, req_data.dport}
                     + {3'd0, req_data.seq_num[31:16]} + {3'd0, req_data.seq_num[15:0]};
    s1_nxt.tcp_b     = {2'd0, DATA_OFF, req_data.flag_bits} + {2'd0, WINDOW}
                     + {2'd0, req_data.sum[31:16]} + {2'd0, req_data.sum[15:0]};
  end

  // Stage two: fold, complement and load the header slot
  assign tcp_total = {3'd0, s1_r.addr_part} + {2'd0, s1_r.tcp_a} + {3'd0, s1_r.tcp_b};
  always_comb begin
    hdr_nxt.src_addr  = s1_r.src_addr;
    hdr_nxt.dst_addr  = s1_r.dst_addr;
    hdr_nxt.sport     = s1_r.sport;
    hdr_nxt.dport     = s1_r.dport;
    hdr_nxt.flag_bits = s1_r.flag_bits;
    hdr_nxt.ttl       = s1_r.ttl;
    hdr_nxt.ident     = s1_r.ident;
    hdr_nxt.seq_num   = s1_r.seq_num;
    hdr_nxt.tot_len   = s1_r.tot_len;
    hdr_nxt.err       = s1_r.err;
    hdr_nxt.ip_ck     = ~fold16({2'd0, s1_r.ip_part});
    hdr_nxt.tcp_ck    = ~fold16(tcp_total);
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (req_pop) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    hdr_v_nxt = hdr_v_r;
    idx_nxt   = idx_r;
    if (s1_adv) begin
      hdr_v_nxt = 1'b1;
      idx_nxt   = WORD_IP0;
    end else if (hdr_done) begin
      hdr_v_nxt = 1'b0;
    end else if (hdr_v_r && out_pop) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      hdr_v_r <= 1'b0;
      idx_r   <= WORD_IP0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      hdr_v_r <= hdr_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      hdr_r <= hdr_nxt;
    end
  end

  assign out_empty        = !hdr_v_r;
  assign out_word_index   = idx_r;
  assign out_length_error = hdr_r.err;
  assign out_last_word    = (idx_r == WORD_TCP);

  always_comb begin
    case (idx_r)
      WORD_IP0:  out_header_word = {VER_IHL, 8'd0, hdr_r.tot_len, hdr_r.ident, 16'd0};
      WORD_IP1:  out_header_word = {hdr_r.ttl, PROTO_TCP, hdr_r.ip_ck, hdr_r.src_addr};
      WORD_ADDR: out_header_word = {hdr_r.dst_addr, hdr_r.sport, hdr_r.dport};
      WORD_SEQ:  out_header_word = {hdr_r.seq_num, 32'd0};
      WORD_TCP:  out_header_word = {DATA_OFF, hdr_r.flag_bits, WINDOW, hdr_r.tcp_ck, 16'd0};
      default:   out_header_word = '0;
    endcase
  end

endmodule

/* hw/rtl/tcp_ipv4_header_builder.sv */
// IPv4/TCP header builder: payload bytes in, 40-byte header out as five words.
// Takes one item per cycle while in_full is low; a last item's request passes
// the queue and stage one to the header slot, which sends one word per cycle
// while out_pop is high. The request queue (REQ_DEPTH) absorbs bursts of short
// packets. Synchronous active-low reset clears sum, count, queue, output slot.
module tcp_ipv4_header_builder #(
  parameter int REQ_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_sport,
  input  logic [15:0] in_dport,
  input  logic [7:0]  in_flag_bits,
  input  logic [7:0]  in_ttl,
  input  logic [15:0] in_ident,
  input  logic [31:0] in_seq_num,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_header_word,
  output logic [2:0]  out_word_index,
  output logic        out_length_error,
  output logic        out_last_word
);
  import thb_pkg::*;

  thb_req_t req_in, req_out;
  logic     req_push, req_full, req_pop, req_empty;

  thb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_src_addr    (in_src_addr),
    .in_dst_addr    (in_dst_addr),
    .in_sport       (in_sport),
    .in_dport       (in_dport),
    .in_flag_bits   (in_flag_bits),
    .in_ttl         (in_ttl),
    .in_ident       (in_ident),
    .in_seq_num     (in_seq_num),
    .in_payload_byte(in_payload_byte),
    .in_byte_valid  (in_byte_valid),
    .in_last        (in_last),
    .req_push       (req_push),
    .req_data       (req_in),
    .req_full       (req_full)
  );

  thb_queue #(
    .DEPTH(REQ_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (req_push),
    .push_data(req_in),
    .full     (req_full),
    .pop      (req_pop),
    .empty    (req_empty),
    .pop_data (req_out)
  );

  thb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (!req_empty),
    .req_data        (req_out),
    .req_pop         (req_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_header_word (out_header_word),
    .out_word_index  (out_word_index),
    .out_length_error(out_length_error),
    .out_last_word   (out_last_word)
  );

  // A header always starts at word zero
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> out_word_index == WORD_IP0)
    else $error("header did not start at word zero");

  // Words of one header follow in order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last_word) |=>
      (!out_empty && out_word_index == $past(out_word_index) + 3'd1))
    else $error("header word skipped or lost");

  // The length flag belongs to the whole header
  a_err_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last_word) |=>
      out_length_error == $past(out_length_error))
    else $error("length flag changed within a header");

  // A request is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    req_push |-> !req_full)
    else $error("request queue overflow");

endmodule
